// ===== design/gaca_pkg.sv =====
// ----------------------------------------------------------------------------
// gaca_pkg
// Shared types and codes of the generations automaton grid engine.
// ----------------------------------------------------------------------------
package gaca_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN_RD,
        ST_SCAN_DEC,
        ST_SCAN_NEXT,
        ST_OP_RD,
        ST_OP_WR,
        ST_NB_CHK,
        ST_NB_WR,
        ST_RES_RD,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_DECAY
    } t_op;

    typedef enum logic [1:0] {
        SW_CLEAR,
        SW_COPY,
        SW_COPY_CLEAR
    } t_sweep;

    localparam logic [2:0] CMD_STEP    = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_REBUILD = 3'd5;

    localparam logic [2:0] REG_BORN    = 3'd0;
    localparam logic [2:0] REG_SURVIVE = 3'd1;
    localparam logic [2:0] REG_DECAY   = 3'd2;
    localparam logic [2:0] REG_NMASK   = 3'd3;
    localparam logic [2:0] REG_THREE_D = 3'd4;
    localparam logic [2:0] REG_SIZE    = 3'd5;

    localparam int         COUNT_W   = 5;
    localparam logic [4:0] COUNT_MAX = 5'd31;
    localparam logic [4:0] COUNT_LIM = 5'd27;

endpackage

// ===== design/gaca_ram.sv =====
// ----------------------------------------------------------------------------
// gaca_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gaca_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/generations_automaton_grid_engine.sv =====
// ----------------------------------------------------------------------------
// generations_automaton_grid_engine
// Generations-style cellular automaton on a 2D or 3D grid with kept counts.
// ----------------------------------------------------------------------------
// One command is taken at a time; o_s_tready stays low until its result is
// loaded. All work goes through the single read and write port of the cell
// memory and of the snapshot memory, driven by a small sequencer. An add or
// remove that moves a cell into or out of the top state then visits each of
// the 27 offset positions and updates the count of every counted in-range
// neighbor. Clear, rebuild and step first sweep the whole memory; step and
// rebuild then scan the active region cell by cell, editing cells as the rules
// require. After reset a clearing pass over the whole memory runs before the
// first command is taken; configuration writes are taken at once.
// ----------------------------------------------------------------------------
module generations_automaton_grid_engine #(
    parameter int GRID_MAX    = 32,
    parameter int STATE_WIDTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // cmd[2:0], x_coord[7:3], y_coord[12:8], z_coord[17:13]
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // cell_state[3:0], neighbour_count[8:4], applied[9]
    // Configuration port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int CW    = $clog2(GRID_MAX);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = STATE_WIDTH;
    localparam int WW    = SW + gaca_pkg::COUNT_W;

    // Configuration registers.
    logic [26:0] r_born;
    logic [26:0] r_surv;
    logic [3:0]  r_decay;
    logic [25:0] r_nmask;
    logic        r_three_d;
    logic [5:0]  r_gsize;

    logic cfg_wr;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_born    <= '0;
            r_surv    <= '0;
            r_decay   <= 4'd1;
            r_nmask   <= '1;
            r_three_d <= 1'b1;
            r_gsize   <= 6'd32;
        end else if (cfg_wr) begin
            case (i_paddr[4:2])
                gaca_pkg::REG_BORN:    r_born    <= i_pwdata[26:0];
                gaca_pkg::REG_SURVIVE: r_surv    <= i_pwdata[26:0];
                gaca_pkg::REG_DECAY:   r_decay   <= i_pwdata[3:0];
                gaca_pkg::REG_NMASK:   r_nmask   <= i_pwdata[25:0];
                gaca_pkg::REG_THREE_D: r_three_d <= i_pwdata[0];
                gaca_pkg::REG_SIZE:    r_gsize   <= i_pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[4:2])
            gaca_pkg::REG_BORN:    o_prdata = {5'd0, r_born};
            gaca_pkg::REG_SURVIVE: o_prdata = {5'd0, r_surv};
            gaca_pkg::REG_DECAY:   o_prdata = {28'd0, r_decay};
            gaca_pkg::REG_NMASK:   o_prdata = {6'd0, r_nmask};
            gaca_pkg::REG_THREE_D: o_prdata = {31'd0, r_three_d};
            gaca_pkg::REG_SIZE:    o_prdata = {26'd0, r_gsize};
            default:               o_prdata = '0;
        endcase
    end

    // Effective size, plane count and top state.
    logic [6:0]    gs7, eff7, zmax7;
    logic [7:0]    ds8, top8;
    logic [SW-1:0] top;
    localparam logic [7:0] SMAX8 = 8'((1 << SW) - 1);

    assign gs7   = {1'b0, r_gsize};
    assign eff7  = (gs7 == 7'd0) ? 7'd1 : ((gs7 > 7'(GRID_MAX)) ? 7'(GRID_MAX) : gs7);
    assign zmax7 = r_three_d ? eff7 : 7'd1;
    assign ds8   = {4'd0, r_decay};
    assign top8  = (ds8 == 8'd0) ? 8'd1 : ((ds8 > SMAX8) ? SMAX8 : ds8);
    assign top   = top8[SW-1:0];

    // Memories.
    logic          cell_we, snap_we;
    logic [AW-1:0] cell_wa, cell_ra, snap_wa, snap_ra;
    logic [WW-1:0] cell_wd, cell_rd, snap_wd, snap_rd;

    gaca_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_wa),
        .i_wdata (cell_wd),
        .i_raddr (cell_ra),
        .o_rdata (cell_rd)
    );

    gaca_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_snap_ram (
        .i_clk   (i_clk),
        .i_we    (snap_we),
        .i_waddr (snap_wa),
        .i_wdata (snap_wd),
        .i_raddr (snap_ra),
        .o_rdata (snap_rd)
    );

    // Sequencer registers.
    gaca_pkg::t_state r_state, n_state;
    gaca_pkg::t_sweep r_sw_mode, n_sw_mode;
    gaca_pkg::t_op    r_op, n_op;
    logic             r_init, n_init;
    logic [AW:0]      r_sw, n_sw;
    logic             r_sw_v, n_sw_v;
    logic [AW-1:0]    r_sw_a, n_sw_a;
    logic [2:0]       r_cmd, n_cmd;
    logic [AW-1:0]    r_ia, n_ia;
    logic             r_inside, n_inside;
    logic             r_applied, n_applied;
    logic             r_in_scan, n_in_scan;
    logic             r_rebuild, n_rebuild;
    logic [CW-1:0]    r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;
    logic [CW-1:0]    r_sx, r_sy, r_sz, n_sx, n_sy, n_sz;
    logic [1:0]       r_dx, r_dy, r_dz, n_dx, n_dy, n_dz;
    logic [4:0]       r_nbit, n_nbit;
    logic             r_up, n_up;
    logic [AW-1:0]    r_na, n_na;
    logic             r_out_v, n_out_v;
    logic [15:0]      r_out_data, n_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gaca_pkg::ST_SWEEP;
            r_sw_mode <= gaca_pkg::SW_CLEAR;
            r_init    <= 1'b1;
            r_sw      <= '0;
            r_sw_v    <= 1'b0;
            r_in_scan <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sw_mode <= n_sw_mode;
            r_init    <= n_init;
            r_sw      <= n_sw;
            r_sw_v    <= n_sw_v;
            r_in_scan <= n_in_scan;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_sw_a     <= n_sw_a;
        r_cmd      <= n_cmd;
        r_ia       <= n_ia;
        r_inside   <= n_inside;
        r_applied  <= n_applied;
        r_rebuild  <= n_rebuild;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_cz       <= n_cz;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_sz       <= n_sz;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_dz       <= n_dz;
        r_nbit     <= n_nbit;
        r_up       <= n_up;
        r_na       <= n_na;
        r_out_data <= n_out_data;
    end

    // Input fields.
    logic [2:0] in_cmd;
    logic [4:0] in_x, in_y, in_z;
    logic       in_inside;
    assign in_cmd    = i_s_tdata[2:0];
    assign in_x      = i_s_tdata[7:3];
    assign in_y      = i_s_tdata[12:8];
    assign in_z      = r_three_d ? i_s_tdata[17:13] : 5'd0;
    assign in_inside = (7'(in_x) < eff7) && (7'(in_y) < eff7) && (7'(in_z) < eff7);

    // Neighbor offset: coordinate plus offset code, where code 1 is no move.
    logic [CW:0]   sum_x, sum_y, sum_z;
    logic [CW-1:0] nx, ny, nz;
    logic          ok_x, ok_y, ok_z, centre, last_off, nb_ok;
    logic [1:0]    adv_dx, adv_dy, adv_dz;

    assign sum_x    = (CW+1)'(r_cx) + (CW+1)'(r_dx);
    assign sum_y    = (CW+1)'(r_cy) + (CW+1)'(r_dy);
    assign sum_z    = (CW+1)'(r_cz) + (CW+1)'(r_dz);
    assign ok_x     = (sum_x != '0) && (7'(sum_x) <= eff7);
    assign ok_y     = (sum_y != '0) && (7'(sum_y) <= eff7);
    assign ok_z     = (sum_z != '0) && (7'(sum_z) <= eff7);
    assign nx       = CW'(sum_x - (CW+1)'(1));
    assign ny       = CW'(sum_y - (CW+1)'(1));
    assign nz       = CW'(sum_z - (CW+1)'(1));
    assign centre   = (r_dx == 2'd1) && (r_dy == 2'd1) && (r_dz == 2'd1);
    assign last_off = (r_dx == 2'd2) && (r_dy == 2'd2) && (r_dz == 2'd2);
    assign nb_ok    = !centre && r_nmask[r_nbit] && (r_three_d || r_dz == 2'd1)
                      && ok_x && ok_y && ok_z;
    assign adv_dz   = (r_dz == 2'd2) ? 2'd0 : r_dz + 2'd1;
    assign adv_dy   = (r_dz == 2'd2) ? ((r_dy == 2'd2) ? 2'd0 : r_dy + 2'd1) : r_dy;
    assign adv_dx   = (r_dz == 2'd2 && r_dy == 2'd2) ? r_dx + 2'd1 : r_dx;

    // Snapshot word decision.
    logic [SW-1:0] s_st, c_st;
    logic [4:0]    s_cnt, c_cnt, c_cnt_adj;
    logic [31:0]   born32, surv32;
    logic          in_born, in_surv;
    assign s_st    = snap_rd[SW-1:0];
    assign s_cnt   = snap_rd[WW-1:SW];
    assign c_st    = cell_rd[SW-1:0];
    assign c_cnt   = cell_rd[WW-1:SW];
    assign born32  = {5'd0, r_born};
    assign surv32  = {5'd0, r_surv};
    assign in_born = (s_cnt < gaca_pkg::COUNT_LIM) && born32[s_cnt];
    assign in_surv = (s_cnt < gaca_pkg::COUNT_LIM) && surv32[s_cnt];
    assign c_cnt_adj = r_up ? ((c_cnt < gaca_pkg::COUNT_MAX) ? c_cnt + 5'd1 : c_cnt)
                            : ((c_cnt != 5'd0) ? c_cnt - 5'd1 : c_cnt);

    logic sx_end, sy_end, sz_end;
    assign sx_end = (7'(r_sx) + 7'd1) >= eff7;
    assign sy_end = (7'(r_sy) + 7'd1) >= eff7;
    assign sz_end = (7'(r_sz) + 7'd1) >= zmax7;

    logic [3:0] res_st;
    assign res_st = 4'(c_st);

    always_comb begin
        n_state    = r_state;
        n_sw_mode  = r_sw_mode;
        n_op       = r_op;
        n_init     = r_init;
        n_sw       = r_sw;
        n_sw_v     = 1'b0;
        n_sw_a     = r_sw_a;
        n_cmd      = r_cmd;
        n_ia       = r_ia;
        n_inside   = r_inside;
        n_applied  = r_applied;
        n_in_scan  = r_in_scan;
        n_rebuild  = r_rebuild;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_cz       = r_cz;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_sz       = r_sz;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_dz       = r_dz;
        n_nbit     = r_nbit;
        n_up       = r_up;
        n_na       = r_na;
        n_out_v    = r_out_v && !i_m_tready;
        n_out_data = r_out_data;

        cell_we = 1'b0;
        cell_wa = {r_cz, r_cy, r_cx};
        cell_wd = '0;
        cell_ra = r_ia;
        snap_we = 1'b0;
        snap_wa = r_sw_a;
        snap_wd = cell_rd;
        snap_ra = {r_sz, r_sy, r_sx};

        o_s_tready = (r_state == gaca_pkg::ST_IDLE);

        case (r_state)
            gaca_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd     = in_cmd;
                    n_ia      = {CW'(in_z), CW'(in_y), CW'(in_x)};
                    n_cx      = CW'(in_x);
                    n_cy      = CW'(in_y);
                    n_cz      = CW'(in_z);
                    n_inside  = in_inside;
                    n_applied = 1'b0;
                    n_in_scan = 1'b0;
                    n_sw      = '0;
                    case (in_cmd)
                        gaca_pkg::CMD_STEP: begin
                            n_sw_mode = gaca_pkg::SW_COPY;
                            n_state   = gaca_pkg::ST_SWEEP;
                        end
                        gaca_pkg::CMD_ADD: begin
                            n_op    = gaca_pkg::OP_ADD;
                            n_state = in_inside ? gaca_pkg::ST_OP_RD : gaca_pkg::ST_RES_RD;
                        end
                        gaca_pkg::CMD_REMOVE: begin
                            n_op    = gaca_pkg::OP_REMOVE;
                            n_state = in_inside ? gaca_pkg::ST_OP_RD : gaca_pkg::ST_RES_RD;
                        end
                        gaca_pkg::CMD_CLEAR: begin
                            n_sw_mode = gaca_pkg::SW_CLEAR;
                            n_state   = gaca_pkg::ST_SWEEP;
                        end
                        gaca_pkg::CMD_REBUILD: begin
                            n_sw_mode = gaca_pkg::SW_COPY_CLEAR;
                            n_state   = gaca_pkg::ST_SWEEP;
                        end
                        default: n_state = gaca_pkg::ST_RES_RD;
                    endcase
                end
            end

            gaca_pkg::ST_SWEEP: begin
                // Read one entry per cycle; the previous entry is cleared, copied to the snapshot, or both.
                cell_ra = r_sw[AW-1:0];
                n_sw_v  = !r_sw[AW];
                n_sw_a  = r_sw[AW-1:0];
                if (!r_sw[AW]) begin
                    n_sw = r_sw + (AW+1)'(1);
                end
                if (r_sw_v) begin
                    if (r_sw_mode != gaca_pkg::SW_COPY) begin
                        cell_we = 1'b1;
                        cell_wa = r_sw_a;
                    end
                    if (r_sw_mode != gaca_pkg::SW_CLEAR) begin
                        snap_we = 1'b1;
                    end
                end
                if (r_sw[AW] && !r_sw_v) begin
                    n_sw = '0;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = gaca_pkg::ST_IDLE;
                    end else if (r_cmd == gaca_pkg::CMD_STEP ||
                                 r_cmd == gaca_pkg::CMD_REBUILD) begin
                        n_rebuild = (r_cmd == gaca_pkg::CMD_REBUILD);
                        n_in_scan = 1'b1;
                        n_sx      = '0;
                        n_sy      = '0;
                        n_sz      = '0;
                        n_state   = gaca_pkg::ST_SCAN_RD;
                    end else begin
                        n_state = gaca_pkg::ST_RES_RD;
                    end
                end
            end

            gaca_pkg::ST_SCAN_RD: begin
                n_state = gaca_pkg::ST_SCAN_DEC;
            end

            gaca_pkg::ST_SCAN_DEC: begin
                n_cx    = r_sx;
                n_cy    = r_sy;
                n_cz    = r_sz;
                n_state = gaca_pkg::ST_SCAN_NEXT;
                if (r_rebuild) begin
                    if (s_st != '0) begin
                        n_op    = gaca_pkg::OP_ADD;
                        n_state = gaca_pkg::ST_OP_RD;
                    end
                end else if (snap_rd != '0) begin
                    if (s_st == '0) begin
                        if (in_born) begin
                            n_op    = gaca_pkg::OP_ADD;
                            n_state = gaca_pkg::ST_OP_RD;
                        end
                    end else if (s_st == top) begin
                        if (!in_surv) begin
                            n_op    = gaca_pkg::OP_DECAY;
                            n_state = gaca_pkg::ST_OP_RD;
                        end
                    end else begin
                        n_op    = gaca_pkg::OP_DECAY;
                        n_state = gaca_pkg::ST_OP_RD;
                    end
                end
            end

            gaca_pkg::ST_SCAN_NEXT: begin
                n_state = gaca_pkg::ST_SCAN_RD;
                if (!sx_end) begin
                    n_sx = r_sx + CW'(1);
                end else begin
                    n_sx = '0;
                    if (!sy_end) begin
                        n_sy = r_sy + CW'(1);
                    end else begin
                        n_sy = '0;
                        if (!sz_end) begin
                            n_sz = r_sz + CW'(1);
                        end else begin
                            n_in_scan = 1'b0;
                            n_state   = gaca_pkg::ST_RES_RD;
                        end
                    end
                end
            end

            gaca_pkg::ST_OP_RD: begin
                cell_ra = {r_cz, r_cy, r_cx};
                n_state = gaca_pkg::ST_OP_WR;
            end

            gaca_pkg::ST_OP_WR: begin
                cell_ra = {r_cz, r_cy, r_cx};
                n_dx    = 2'd0;
                n_dy    = 2'd0;
                n_dz    = 2'd0;
                n_nbit  = '0;
                n_state = r_in_scan ? gaca_pkg::ST_SCAN_NEXT : gaca_pkg::ST_RES_RD;
                case (r_op)
                    gaca_pkg::OP_ADD: begin
                        if (c_st == '0) begin
                            cell_we   = 1'b1;
                            cell_wd   = {c_cnt, top};
                            n_applied = !r_in_scan;
                            n_up      = 1'b1;
                            n_state   = gaca_pkg::ST_NB_CHK;
                        end
                    end
                    gaca_pkg::OP_REMOVE: begin
                        if (c_st != '0) begin
                            cell_we   = 1'b1;
                            cell_wd   = {c_cnt, {SW{1'b0}}};
                            n_applied = !r_in_scan;
                            n_up      = 1'b0;
                            if (c_st == top) begin
                                n_state = gaca_pkg::ST_NB_CHK;
                            end
                        end
                    end
                    gaca_pkg::OP_DECAY: begin
                        if (c_st != '0) begin
                            cell_we = 1'b1;
                            cell_wd = {c_cnt, c_st - SW'(1)};
                            n_up    = 1'b0;
                            if (c_st == top) begin
                                n_state = gaca_pkg::ST_NB_CHK;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            gaca_pkg::ST_NB_CHK, gaca_pkg::ST_NB_WR: begin
                if (r_state == gaca_pkg::ST_NB_CHK && nb_ok) begin
                    cell_ra = {nz, ny, nx};
                    n_na    = {nz, ny, nx};
                    n_state = gaca_pkg::ST_NB_WR;
                end else begin
                    if (r_state == gaca_pkg::ST_NB_WR) begin
                        cell_ra = r_na;
                        cell_we = 1'b1;
                        cell_wa = r_na;
                        cell_wd = {c_cnt_adj, c_st};
                    end
                    if (last_off) begin
                        n_state = r_in_scan ? gaca_pkg::ST_SCAN_NEXT : gaca_pkg::ST_RES_RD;
                    end else begin
                        n_dx    = adv_dx;
                        n_dy    = adv_dy;
                        n_dz    = adv_dz;
                        n_nbit  = centre ? r_nbit : r_nbit + 5'd1;
                        n_state = gaca_pkg::ST_NB_CHK;
                    end
                end
            end

            gaca_pkg::ST_RES_RD: begin
                n_state = gaca_pkg::ST_DONE;
            end

            gaca_pkg::ST_DONE: begin
                if (!r_out_v || i_m_tready) begin
                    n_out_v    = 1'b1;
                    n_out_data = r_inside ? {6'd0, r_applied, c_cnt, res_st} : 16'd0;
                    n_state    = gaca_pkg::ST_IDLE;
                end
            end

            default: n_state = gaca_pkg::ST_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== design/gaca_checker.sv =====
// ----------------------------------------------------------------------------
// gaca_checker
// Port-level checks of the grid engine, bound to the top level.
// ----------------------------------------------------------------------------
module gaca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_pready
);

    // A result held back by the sink keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Commands are worked one at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command taken while busy");

    // A new result only appears at the end of a command's work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result without a command");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready && o_pready)
        else $error("outputs active after reset");

endmodule

bind generations_automaton_grid_engine gaca_checker u_gaca_checker (.*);
